// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/crfb_pkg.sv =====
// ----------------------------------------------------------------------------
// crfb_pkg
// Constants and the CRC-16 byte update for the response frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crfb_pkg;

  localparam logic [7:0]  START_MARK    = 8'h4F;
  localparam logic [7:0]  VERSION_MARK  = 8'h02;
  localparam logic [7:0]  RESPONSE_TYPE = 8'h02;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam int HDR_BYTES = 17;
  localparam int HDR_W     = HDR_BYTES * 8;
  localparam int POS_W     = 5;

  localparam logic [POS_W-1:0] HDR_LAST_POS   = POS_W'(HDR_BYTES - 1);
  localparam logic [POS_W-1:0] HDR_CRC_HI_POS = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] HDR_CRC_LO_POS = POS_W'(HDR_BYTES + 1);
  localparam logic [POS_W-1:0] PAY_CRC_HI_POS = POS_W'(1);
  localparam logic [POS_W-1:0] PAY_CRC_LO_POS = POS_W'(2);

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/crc16_response_frame_builder.sv =====
// A start item with the link up emits the 17-byte header, then the CRC-16
// (init 0xFFFF, poly 0x1021, big-endian) when the payload length is zero;
// each payload item emits its byte, and the last counted one is followed by
// the CRC. Lengths saturate at MAX_PAYLOAD. chunk_last marks every
// CHUNK_BYTES-th byte and the frame end. Timing: one item register feeds one
// output register through a single byte-wide path, so the block emits one
// byte per cycle while out_stall is low. A payload item emits its byte, and
// the CRC after it when it closes the frame; a start item emits its header,
// and the CRC after it with an empty payload. The next item is taken in the
// cycle its predecessor's last byte enters the output register.
// ----------------------------------------------------------------------------
// crc16_response_frame_builder
// Byte-serial response framer with header, payload pass-through and CRC-16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_response_frame_builder #(
  parameter int MAX_PAYLOAD = 490,
  parameter int CHUNK_BYTES = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  cmd_code,
  input  logic [15:0] seq_num,
  input  logic [7:0]  status_code,
  input  logic [15:0] payload_length,
  input  logic [63:0] timestamp_ms,
  input  logic        link_up,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        chunk_last,
  output logic        frame_last
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CHK_W = $clog2(CHUNK_BYTES + 1);

  // item register
  logic                      item_valid;
  logic [crfb_pkg::POS_W-1:0] pos;
  logic                      r_command;
  logic [7:0]                r_cmd_code;
  logic [15:0]               r_seq_num;
  logic [7:0]                r_status_code;
  logic [15:0]               r_payload_length;
  logic [63:0]               r_timestamp_ms;
  logic                      r_link_up;
  logic [7:0]                r_data_byte;

  // frame state
  logic             frame_active;
  logic [CNT_W-1:0] remaining;
  logic [15:0]      crc;
  logic [CHK_W-1:0] chunk_pos;

  logic [15:0]                  len_sat;
  logic [crfb_pkg::HDR_W-1:0]   hdr;
  logic [crfb_pkg::POS_W-1:0]   hdr_idx;
  logic                         has_byte;
  logic                         item_last;
  logic [7:0]                   byte_sel;
  logic                         into_crc;
  logic                         is_final;
  logic                         frame_start;
  logic                         payload_take;
  logic                         out_free;
  logic                         fire;
  logic                         consume;
  logic                         accept;
  logic [15:0]                  crc_in;
  logic [15:0]                  crc_next;
  logic [CHK_W-1:0]             chunk_cur;
  logic [CHK_W-1:0]             chunk_inc;
  logic                         chunk_end;
  logic [CHK_W-1:0]             chunk_pos_next;

  always_comb begin
    len_sat = (r_payload_length > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : r_payload_length;
    hdr = {crfb_pkg::START_MARK, crfb_pkg::VERSION_MARK, crfb_pkg::RESPONSE_TYPE,
           r_cmd_code, r_seq_num, len_sat, r_status_code, r_timestamp_ms};
    hdr_idx      = crfb_pkg::HDR_LAST_POS - pos;
    has_byte     = 1'b0;
    item_last    = 1'b1;
    byte_sel     = r_data_byte;
    into_crc     = 1'b0;
    is_final     = 1'b0;
    frame_start  = 1'b0;
    payload_take = 1'b0;
    if (r_command == crfb_pkg::CMD_START) begin
      if (r_link_up) begin
        has_byte = 1'b1;
        if (pos <= crfb_pkg::HDR_LAST_POS) begin
          byte_sel    = hdr[{hdr_idx, 3'b000} +: 8];
          into_crc    = 1'b1;
          frame_start = (pos == '0);
          item_last   = (pos == crfb_pkg::HDR_LAST_POS) && (len_sat != '0);
        end else begin
          byte_sel  = (pos == crfb_pkg::HDR_CRC_HI_POS) ? crc[15:8] : crc[7:0];
          is_final  = (pos == crfb_pkg::HDR_CRC_LO_POS);
          item_last = is_final;
        end
      end
    end else begin
      if (pos == '0) begin
        if (frame_active && (remaining != '0)) begin
          has_byte     = 1'b1;
          byte_sel     = r_data_byte;
          into_crc     = 1'b1;
          payload_take = 1'b1;
          item_last    = (remaining != CNT_W'(1));
        end
      end else begin
        has_byte  = 1'b1;
        byte_sel  = (pos == crfb_pkg::PAY_CRC_HI_POS) ? crc[15:8] : crc[7:0];
        is_final  = (pos == crfb_pkg::PAY_CRC_LO_POS);
        item_last = is_final;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && has_byte && out_free;
  assign consume  = item_valid && item_last && (!has_byte || out_free);
  assign in_stall = item_valid && !consume;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    crc_in   = frame_start ? crfb_pkg::CRC_INIT : crc;
    crc_next = crc;
    if (into_crc) begin
      crc_next = crfb_pkg::crc_feed(crc_in, byte_sel);
    end
    if (is_final) begin
      crc_next = crfb_pkg::CRC_INIT;
    end
    chunk_cur      = frame_start ? '0 : chunk_pos;
    chunk_inc      = chunk_cur + CHK_W'(1);
    chunk_end      = (chunk_inc >= CHK_W'(CHUNK_BYTES)) || is_final;
    chunk_pos_next = chunk_end ? '0 : chunk_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      pos          <= '0;
      out_valid    <= 1'b0;
      frame_active <= 1'b0;
      remaining    <= '0;
      crc          <= crfb_pkg::CRC_INIT;
      chunk_pos    <= '0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
        pos        <= '0;
      end else if (consume) begin
        item_valid <= 1'b0;
        pos        <= '0;
      end else if (fire) begin
        pos <= pos + crfb_pkg::POS_W'(1);
      end

      if (fire) begin
        out_valid <= 1'b1;
        crc       <= crc_next;
        chunk_pos <= chunk_pos_next;
        if (frame_start) begin
          frame_active <= 1'b1;
          remaining    <= len_sat[CNT_W-1:0];
        end else if (payload_take) begin
          remaining <= remaining - CNT_W'(1);
        end else if (is_final) begin
          frame_active <= 1'b0;
          remaining    <= '0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_command        <= command;
      r_cmd_code       <= cmd_code;
      r_seq_num        <= seq_num;
      r_status_code    <= status_code;
      r_payload_length <= payload_length;
      r_timestamp_ms   <= timestamp_ms;
      r_link_up        <= link_up;
      r_data_byte      <= data_byte;
    end
    if (fire) begin
      out_byte   <= byte_sel;
      chunk_last <= chunk_end;
      frame_last <= is_final;
    end
  end

  `ASSERT_ALWAYS(a_final_ends_chunk, !(out_valid && frame_last) || chunk_last)
  `ASSERT_ALWAYS(a_pos_bound, !item_valid || (pos <= crfb_pkg::HDR_CRC_LO_POS))
  `ASSERT_ALWAYS(a_idle_no_count, frame_active || (remaining == '0))
  `ASSERT_NEXT(a_final_closes, fire && is_final, !frame_active && (crc == crfb_pkg::CRC_INIT))

endmodule
